// ===== rtl/core/tdw_pkg.sv =====
// Shared types and constants for the tape delay waveshaper.
`timescale 1ns / 1ps

package tdw_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int STORE_W     = 17;
   localparam int DELAY_W     = 15;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Default ring depth in samples
   localparam int DEF_BUFFER_DEPTH = 32768;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_SAMPLES     = 3'd0,
      CSR_FEEDBACK_GAIN     = 3'd1,
      CSR_DISTORTION_AMOUNT = 3'd2,
      CSR_HISS_AMOUNT       = 3'd3,
      CSR_DISTORT_MODE      = 3'd4
   } csr_index_type;

   // Request payload
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic signed [SAMPLE_W-1:0] noise_sample;
      logic                       last_in_block;
   } req_type;

   // Result payload
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] output_sample;
      logic                       last_out;
   } rsp_type;

   // Control registers
   typedef struct packed {
      logic [DELAY_W-1:0] delay_samples;
      logic [GAIN_W-1:0]  feedback_gain;
      logic [GAIN_W-1:0]  distortion_amount;
      logic [GAIN_W-1:0]  hiss_amount;
      logic               distort_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      delay_samples:     15'd4410,
      feedback_gain:     16'd0,
      distortion_amount: 16'd0,
      hiss_amount:       16'd0,
      distort_mode:      1'b0
   };

   // Datapath to ring access commands
   typedef struct packed {
      logic                      wr_en;
      logic                      rd_en;
      logic signed [STORE_W-1:0] wdata;
   } ring_cmd_type;

   // Top level to datapath control
   typedef struct packed {
      logic start;
      logic out_free;
   } dp_ctrl_type;

   // Datapath to top level status
   typedef struct packed {
      logic idle;
      logic rsp_load;
   } dp_status_type;

endpackage

// ===== rtl/core/tdw_delay_ring.sv =====
// Delay ring: sample store, write pointer, fill tracking and tap addressing.
`timescale 1ns / 1ps

module tdw_delay_ring #(
   parameter int BUFFER_DEPTH = tdw_pkg::DEF_BUFFER_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tdw_pkg::ring_cmd_type              cmd,
   input  logic [tdw_pkg::DELAY_W-1:0]        delay_samples,
   output logic signed [tdw_pkg::STORE_W-1:0] tap
);
   import tdw_pkg::*;

   localparam int AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int AWX = AW + 1;
   localparam logic [AW-1:0]  LAST_POS = AW'(BUFFER_DEPTH - 1);
   localparam logic [AWX-1:0] DEPTH_X  = AWX'(BUFFER_DEPTH);
   localparam logic [31:0]    DEPTH_32 = 32'(BUFFER_DEPTH);
   // Reciprocal for the delay modulo depth reduction
   localparam logic [32:0]    DIV_RECIP = 33'((64'd1 << 32) / BUFFER_DEPTH);

   logic signed [STORE_W-1:0] store_mem [BUFFER_DEPTH];

   logic [AW-1:0]             wp_ff;
   logic                      wrapped_ff;
   logic [DELAY_W-1:0]        q_ff;
   logic [AW-1:0]             dm_ff;
   logic signed [STORE_W-1:0] rdata_ff;
   logic                      tap_ok_ff;

   logic [47:0]               qprod;
   logic [31:0]               rem_raw;
   logic [31:0]               rem_fix;
   logic [AWX-1:0]            diff;
   logic [AWX-1:0]            diff_wrap;
   logic [AW-1:0]             rd_addr;
   logic                      rd_ok;

   // Delay modulo depth: reciprocal estimate, then one correction step
   assign qprod   = 48'(delay_samples) * 48'(DIV_RECIP);
   assign rem_raw = 32'(delay_samples) - 32'(q_ff) * DEPTH_32;
   assign rem_fix = (rem_raw >= DEPTH_32) ? (rem_raw - DEPTH_32) : rem_raw;

   always_ff @(posedge clock) begin
      q_ff  <= qprod[46:32];
      dm_ff <= rem_fix[AW-1:0];
   end

   // Tap address behind the (already advanced) write pointer
   assign diff      = {1'b0, wp_ff} - {1'b0, dm_ff};
   assign diff_wrap = diff + DEPTH_X;
   assign rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

   // Entries below the pointer are written; all are once the ring has wrapped
   assign rd_ok = wrapped_ff || (rd_addr < wp_ff);

   // Write pointer and fill flag
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         tap_ok_ff  <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            if (wp_ff == LAST_POS) begin
               wp_ff      <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               wp_ff <= wp_ff + AW'(1);
            end
         end
         if (cmd.rd_en) begin
            tap_ok_ff <= rd_ok;
         end
      end
   end

   // Sample store, one write and one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[wp_ff] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   // Never-written entries read as zero
   assign tap = tap_ok_ff ? rdata_ff : '0;

endmodule

// ===== rtl/core/tdw_datapath.sv =====
// Sample sequencer: feedback, shaper curves and mix on one shared multiplier.
`timescale 1ns / 1ps

module tdw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tdw_pkg::dp_ctrl_type              ctrl,
   input  tdw_pkg::req_type                  req,
   input  tdw_pkg::cfg_type                  cfg,
   input  logic signed [tdw_pkg::STORE_W-1:0] tap,
   output tdw_pkg::ring_cmd_type             ring_cmd,
   output tdw_pkg::dp_status_type            status,
   output tdw_pkg::rsp_type                  rsp
);
   import tdw_pkg::*;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 64;

   // Fixed point constants
   localparam logic signed [MUL_W-1:0] K_LOG2_10   = 33'sd217706;
   localparam logic signed [MUL_W-1:0] K_LOG2_9    = 33'sd207744;
   localparam logic signed [MUL_W-1:0] K_LN2       = 33'sd744261118;
   localparam logic signed [MUL_W-1:0] K_TRI_NEG   = 33'sd58982;
   localparam logic signed [MUL_W-1:0] K_TRI_GAIN  = 33'sd78643;
   localparam logic signed [MUL_W-1:0] K_TRI_NGAIN = -33'sd78643;
   localparam logic signed [MUL_W-1:0] K_PENT_GAIN = 33'sd72811;
   localparam logic signed [MUL_W-1:0] K_HISS      = 33'sd983;
   localparam logic [30:0]             Q30_ONE     = 31'h4000_0000;
   localparam logic [4:0]              SHIFT_LIMIT = 5'd31;
   localparam logic [2:0]              TERMS       = 3'd6;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_READ, S_TAP, S_FB, S_NOISE, S_HISS, S_DRY,
      S_SQ, S_NEG, S_TRIG, S_Z, S_Y, S_T1, S_T2, S_T3, S_P, S_PM,
      S_MAG, S_WET, S_OUT
   } state_type;

   // Reciprocal of the series term index, exact for 30-bit dividends
   function automatic logic [30:0] term_recip(input logic [2:0] k);
      logic [30:0] m;
      unique case (k)
         3'd3:    m = 31'd1431655766;
         3'd5:    m = 31'd1717986919;
         3'd6:    m = 31'd1431655766;
         default: m = Q30_ONE;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] term_shift(input logic [2:0] k);
      logic [5:0] s;
      unique case (k)
         3'd2:       s = 6'd31;
         3'd3, 3'd4: s = 6'd32;
         3'd5, 3'd6: s = 6'd33;
         default:    s = 6'd30;
      endcase
      return s;
   endfunction

   state_type                  state_ff;
   logic signed [STORE_W-1:0]  mix_ff;
   logic signed [SAMPLE_W-1:0] noise_ff;
   logic                       last_ff;
   logic signed [18:0]         x_ff;
   logic signed [39:0]         acc_ff;
   logic [4:0]                 n_ff;
   logic [29:0]                y_ff;
   logic [30:0]                t_ff;
   logic [2:0]                 k_ff;
   logic [30:0]                om_ff;
   logic signed [PROD_W-1:0]   prod_ff;

   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [2*MUL_W-1:0]  mul_full;
   logic                       x_pos;
   logic [18:0]                ax;
   logic [16:0]                dry_gain;
   logic signed [MUL_W-1:0]    d_pos;
   logic signed [MUL_W-1:0]    d_neg;
   logic [61:0]                quot_wide;
   logic [29:0]                quot;
   logic [30:0]                pow_raw;
   logic [30:0]                pow_cap;
   logic signed [23:0]         res_wide;
   logic signed [SAMPLE_W-1:0] res_sat;

   assign x_pos    = !x_ff[18] && (x_ff != '0);
   assign ax       = x_ff[18] ? 19'(-x_ff) : x_ff;
   assign dry_gain = 17'h1_0000 - {1'b0, cfg.distortion_amount};
   assign d_pos    = {17'b0, cfg.distortion_amount};
   assign d_neg    = -d_pos;

   // Shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_TAP: begin
            mul_a = MUL_W'(tap);
            mul_b = {17'b0, cfg.feedback_gain};
         end
         S_FB: begin
            mul_a = MUL_W'(noise_ff);
            mul_b = {17'b0, cfg.hiss_amount};
         end
         S_NOISE: begin
            mul_a = prod_ff[32:0];
            mul_b = K_HISS;
         end
         S_HISS: begin
            mul_a = MUL_W'(x_ff);
            mul_b = {16'b0, dry_gain};
         end
         S_DRY: begin
            if (cfg.distort_mode) begin
               mul_a = {14'b0, ax};
               mul_b = x_pos ? K_LOG2_10 : K_LOG2_9;
            end else begin
               mul_a = MUL_W'(x_ff);
               mul_b = MUL_W'(x_ff);
            end
         end
         S_SQ: begin
            mul_a = {13'b0, prod_ff[34:15]};
            mul_b = x_pos ? K_TRI_GAIN : K_TRI_NEG;
         end
         S_NEG: begin
            mul_a = {13'b0, prod_ff[35:16]};
            mul_b = K_TRI_NGAIN;
         end
         S_TRIG: begin
            mul_a = MUL_W'($signed(prod_ff[37:16]));
            mul_b = d_pos;
         end
         S_Z: begin
            mul_a = {17'b0, prod_ff[30:15]};
            mul_b = K_LN2;
         end
         S_T1: begin
            mul_a = {3'b0, y_ff};
            mul_b = {2'b0, t_ff};
         end
         S_T2: begin
            mul_a = {3'b0, prod_ff[59:30]};
            mul_b = {2'b0, term_recip(k_ff)};
         end
         S_PM: begin
            mul_a = {2'b0, om_ff};
            mul_b = K_PENT_GAIN;
         end
         S_MAG: begin
            mul_a = {17'b0, prod_ff[46:31]};
            mul_b = x_pos ? d_pos : d_neg;
         end
         default: begin
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Series term quotient and power of two scaling
   assign quot_wide = prod_ff[61:0] >> term_shift(k_ff);
   assign quot      = quot_wide[29:0];
   assign pow_raw   = (n_ff == SHIFT_LIMIT) ? '0 : (t_ff >> n_ff);
   assign pow_cap   = (pow_raw > Q30_ONE) ? Q30_ONE : pow_raw;

   // Output scaling and saturation
   assign res_wide = acc_ff[39:16];
   always_comb begin
      if (res_wide > 24'sd32767) begin
         res_sat = 16'sh7FFF;
      end else if (res_wide < -24'sd32768) begin
         res_sat = -16'sh8000;
      end else begin
         res_sat = res_wide[15:0];
      end
   end

   // Sequencer state and working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[PROD_W-1:0];
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (ctrl.start) begin
                  mix_ff   <= STORE_W'(req.left_sample) + STORE_W'(req.right_sample);
                  noise_ff <= req.noise_sample;
                  last_ff  <= req.last_in_block;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_READ;
            S_READ:  state_ff <= S_TAP;
            S_TAP:   state_ff <= S_FB;
            S_FB: begin
               x_ff     <= {{2{mix_ff[16]}}, mix_ff} + prod_ff[34:16];
               state_ff <= S_NOISE;
            end
            S_NOISE: state_ff <= S_HISS;
            S_HISS: begin
               acc_ff   <= prod_ff[55:16];
               state_ff <= S_DRY;
            end
            S_DRY: begin
               acc_ff   <= acc_ff + prod_ff[39:0];
               state_ff <= cfg.distort_mode ? S_Z : S_SQ;
            end
            S_SQ:   state_ff <= x_pos ? S_TRIG : S_NEG;
            S_NEG:  state_ff <= S_TRIG;
            S_TRIG: state_ff <= S_WET;
            S_Z: begin
               n_ff     <= prod_ff[35:31];
               state_ff <= S_Y;
            end
            S_Y: begin
               y_ff     <= prod_ff[45:16];
               t_ff     <= Q30_ONE;
               k_ff     <= TERMS;
               state_ff <= S_T1;
            end
            S_T1: state_ff <= S_T2;
            S_T2: state_ff <= S_T3;
            S_T3: begin
               t_ff     <= Q30_ONE - {1'b0, quot};
               k_ff     <= k_ff - 3'd1;
               state_ff <= (k_ff == 3'd1) ? S_P : S_T1;
            end
            S_P: begin
               om_ff    <= Q30_ONE - pow_cap;
               state_ff <= S_PM;
            end
            S_PM:  state_ff <= S_MAG;
            S_MAG: state_ff <= S_WET;
            S_WET: begin
               acc_ff   <= acc_ff + prod_ff[39:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (ctrl.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Ring access: store the mono sum, then fetch the tap
   assign ring_cmd.wr_en = (state_ff == S_WRITE);
   assign ring_cmd.rd_en = (state_ff == S_READ);
   assign ring_cmd.wdata = mix_ff;

   assign status.idle     = (state_ff == S_IDLE);
   assign status.rsp_load = (state_ff == S_OUT) && ctrl.out_free;

   assign rsp.output_sample = res_sat;
   assign rsp.last_out      = last_ff;

endmodule

// ===== rtl/core/tape_delay_waveshaper.sv =====
// Top level of the tape delay waveshaper: control registers, handshakes, ring and datapath.
// A taken request is sequenced on the shared multiplier: ring access, feedback, hiss, dry
// mix, then the curve: the triode curve adds a negation step at zero or negative input and
// the pentode curve runs six series terms, each in states S_T1, S_T2 and S_T3. One request
// is in flight: a new one is taken once the result is loaded. Reset is synchronous, active
// high, and clears control state, write pointer and fill flag; the store is not swept.
`timescale 1ns / 1ps

module tape_delay_waveshaper #(
   parameter int BUFFER_DEPTH = tdw_pkg::DEF_BUFFER_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tdw_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tdw_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tdw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tdw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tdw_pkg::*;

   cfg_type                   cfg_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   dp_ctrl_type               dp_ctrl;
   dp_status_type             dp_status;
   rsp_type                   dp_rsp;
   ring_cmd_type              ring_cmd;
   logic signed [STORE_W-1:0] tap;

   // Control registers, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY_SAMPLES:     cfg_ff.delay_samples     <= csr_data[DELAY_W-1:0];
            CSR_FEEDBACK_GAIN:     cfg_ff.feedback_gain     <= csr_data[GAIN_W-1:0];
            CSR_DISTORTION_AMOUNT: cfg_ff.distortion_amount <= csr_data[GAIN_W-1:0];
            CSR_HISS_AMOUNT:       cfg_ff.hiss_amount       <= csr_data[GAIN_W-1:0];
            CSR_DISTORT_MODE:      cfg_ff.distort_mode      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Request side
   assign req_ready        = dp_status.idle;
   assign dp_ctrl.start    = req_valid && req_ready;
   assign dp_ctrl.out_free = !rsp_valid_ff || rsp_ready;

   // Result register decouples the datapath from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_status.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_status.rsp_load) begin
         rsp_ff <= dp_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tdw_delay_ring #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_ring (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ring_cmd),
      .delay_samples (cfg_ff.delay_samples),
      .tap           (tap)
   );

   tdw_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dp_ctrl),
      .req      (req_data),
      .cfg      (cfg_ff),
      .tap      (tap),
      .ring_cmd (ring_cmd),
      .status   (dp_status),
      .rsp      (dp_rsp)
   );

endmodule

// ===== rtl/core/tdw_checker.sv =====
// Port-level checker for the tape delay waveshaper, bound to the top level.
`timescale 1ns / 1ps

module tdw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tdw_pkg::rsp_type rsp_data
);

   // Reset leaves no result pending
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // One request in flight: ready drops after a request is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // A fresh result never follows a request in the very next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared too soon after a request");

endmodule

bind tape_delay_waveshaper tdw_checker u_tdw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
